>>> sv/pba_pkg.sv
// Shared constants and types for the Poly1305 block accumulator.
`timescale 1ns / 1ps

package pba_pkg;

   localparam int NUM_LIMBS = 5;
   localparam int LIMB_W    = 26;
   localparam int HACC_W    = LIMB_W + 1;
   localparam int A_W       = HACC_W + 1;
   localparam int COEF_W    = LIMB_W + 3;
   localparam int LACC_W    = COEF_W + 3;
   localparam int D_W       = LACC_W + A_W;
   localparam int C_W       = D_W + 1 - LIMB_W;
   localparam int F_W       = C_W + 3;
   localparam int CNT_W     = $clog2(A_W);
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_R_LIMB0,
      CSR_R_LIMB1,
      CSR_R_LIMB2,
      CSR_R_LIMB3,
      CSR_R_LIMB4
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_CHAIN,
      ST_FOLD,
      ST_CARRY,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic clear;
      logic step;
      logic shift;
   } lane_ctl_type;

endpackage

>>> sv/pba_if.sv
// Request and response channel interfaces of the block accumulator.
`timescale 1ns / 1ps

interface pba_req_if;
   import pba_pkg::*;

   logic              valid;
   logic              ready;
   logic              mode;
   logic [LIMB_W-1:0] msg_limb0;
   logic [LIMB_W-1:0] msg_limb1;
   logic [LIMB_W-1:0] msg_limb2;
   logic [LIMB_W-1:0] msg_limb3;
   logic [LIMB_W-1:0] msg_limb4;

   modport source (
      output valid, mode, msg_limb0, msg_limb1, msg_limb2, msg_limb3, msg_limb4,
      input  ready
   );
   modport sink (
      input  valid, mode, msg_limb0, msg_limb1, msg_limb2, msg_limb3, msg_limb4,
      output ready
   );
endinterface

interface pba_rsp_if;
   import pba_pkg::*;

   logic              valid;
   logic              ready;
   logic [LIMB_W-1:0] acc_limb0;
   logic [HACC_W-1:0] acc_limb1;
   logic [LIMB_W-1:0] acc_limb2;
   logic [LIMB_W-1:0] acc_limb3;
   logic [LIMB_W-1:0] acc_limb4;

   modport source (
      output valid, acc_limb0, acc_limb1, acc_limb2, acc_limb3, acc_limb4,
      input  ready
   );
   modport sink (
      input  valid, acc_limb0, acc_limb1, acc_limb2, acc_limb3, acc_limb4,
      output ready
   );
endinterface

>>> sv/poly1305_block_accumulate.sv
// Poly1305 block accumulator: (h + m) * r mod 2^130-5 in 26-bit limbs, or m * r when mode is set.
// Steps after the accepting edge: bit-serial multiply, limb-serial carry chain,
//   fold, final carry, output load.
// A new block is accepted only in idle, after the previous result is loaded; the
//   pace is set by the bit-serial multiply over 28-bit summed limbs and carry chain.
// Reset (synchronous): accumulator and key r cleared, channels idle.
`timescale 1ns / 1ps

module poly1305_block_accumulate (
   input  logic                             clock,
   input  logic                             reset,
   pba_req_if.sink                          req_bus,
   pba_rsp_if.source                        rsp_bus,
   input  logic                             csr_we,
   input  logic [pba_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pba_pkg::LIMB_W-1:0]       csr_wdata
);
   import pba_pkg::*;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [LIMB_W-1:0]  r_ff   [NUM_LIMBS];
   logic [COEF_W-1:0]  s_ff   [NUM_LIMBS];
   logic [HACC_W-1:0]  acc_ff [NUM_LIMBS];
   logic [A_W-1:0]     a_ff   [NUM_LIMBS];
   logic [HACC_W-1:0]  h_ff   [NUM_LIMBS];
   logic [HACC_W-1:0]  out_ff [NUM_LIMBS];
   logic [C_W-1:0]     c_ff;

   logic [LIMB_W-1:0]  msg    [NUM_LIMBS];
   logic [COEF_W-1:0]  coef   [NUM_LIMBS][NUM_LIMBS];
   logic [D_W-1:0]     lane_d [NUM_LIMBS + 1];
   logic [NUM_LIMBS-1:0] a_bits;
   logic [COEF_W-1:0]  s_wdata;
   logic [D_W:0]       chain_sum;
   logic [F_W-1:0]     fold_sum;
   logic               accept;
   logic               load_out;
   lane_ctl_type       lane_ctl;

   assign accept   = req_bus.valid && req_bus.ready;
   assign load_out = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_bus.ready);

   assign msg[0] = req_bus.msg_limb0;
   assign msg[1] = req_bus.msg_limb1;
   assign msg[2] = req_bus.msg_limb2;
   assign msg[3] = req_bus.msg_limb3;
   assign msg[4] = req_bus.msg_limb4;

   // ---------------- key registers ----------------
   assign s_wdata = (COEF_W'(csr_wdata) << 2) + COEF_W'(csr_wdata);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_LIMBS; k++) begin
            r_ff[k] <= '0;
            s_ff[k] <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            CSR_R_LIMB0: begin r_ff[0] <= csr_wdata; s_ff[0] <= s_wdata; end
            CSR_R_LIMB1: begin r_ff[1] <= csr_wdata; s_ff[1] <= s_wdata; end
            CSR_R_LIMB2: begin r_ff[2] <= csr_wdata; s_ff[2] <= s_wdata; end
            CSR_R_LIMB3: begin r_ff[3] <= csr_wdata; s_ff[3] <= s_wdata; end
            CSR_R_LIMB4: begin r_ff[4] <= csr_wdata; s_ff[4] <= s_wdata; end
            default: ;
         endcase
      end
   end

   // column j takes a[i]*r[j-i], wrapping to a[i]*5r[j-i+5]
   always_comb begin
      for (int j = 0; j < NUM_LIMBS; j++) begin
         for (int i = 0; i < NUM_LIMBS; i++) begin
            if (i <= j) begin
               coef[j][i] = COEF_W'(r_ff[j-i]);
            end else begin
               coef[j][i] = s_ff[j-i+NUM_LIMBS];
            end
         end
      end
   end

   // ---------------- control ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_MUL;
         ST_MUL:   if (cnt_ff == CNT_W'(A_W - 1)) state_in = ST_CHAIN;
         ST_CHAIN: if (cnt_ff == CNT_W'(NUM_LIMBS - 1)) state_in = ST_FOLD;
         ST_FOLD:  state_in = ST_CARRY;
         ST_CARRY: state_in = ST_DONE;
         ST_DONE:  if (load_out) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      lane_ctl      = '0;
      cnt_in        = '0;
      req_bus.ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_bus.ready  = 1'b1;
            lane_ctl.clear = accept;
         end
         ST_MUL: begin
            lane_ctl.step = 1'b1;
            cnt_in = (cnt_ff == CNT_W'(A_W - 1)) ? '0 : cnt_ff + 1'b1;
         end
         ST_CHAIN: begin
            lane_ctl.shift = 1'b1;
            cnt_in = (cnt_ff == CNT_W'(NUM_LIMBS - 1)) ? '0 : cnt_ff + 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NUM_LIMBS; k++) begin
            acc_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (load_out) begin
            for (int k = 0; k < NUM_LIMBS; k++) begin
               acc_ff[k] <= h_ff[k];
            end
         end
      end
   end

   // ---------------- multiply lanes ----------------
   always_comb begin
      for (int i = 0; i < NUM_LIMBS; i++) begin
         a_bits[i] = a_ff[i][0];
      end
   end

   assign lane_d[NUM_LIMBS] = '0;

   for (genvar j = 0; j < NUM_LIMBS; j++) begin : g_lane
      pba_mac_lane u_lane (
         .clock  (clock),
         .ctl    (lane_ctl),
         .a_bits (a_bits),
         .coef   (coef[j]),
         .d_in   (lane_d[j+1]),
         .d_out  (lane_d[j])
      );
   end

   // ---------------- datapath ----------------
   assign chain_sum = {1'b0, lane_d[0]} + (D_W + 1)'(c_ff);
   assign fold_sum  = F_W'(h_ff[0]) + F_W'(c_ff) + F_W'({c_ff, 2'b00});

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               for (int i = 0; i < NUM_LIMBS; i++) begin
                  a_ff[i] <= (req_bus.mode ? '0 : A_W'(acc_ff[i])) + A_W'(msg[i]);
               end
               c_ff <= '0;
            end
         end
         ST_MUL: begin
            for (int i = 0; i < NUM_LIMBS; i++) begin
               a_ff[i] <= a_ff[i] >> 1;
            end
         end
         ST_CHAIN: begin
            for (int k = 0; k < NUM_LIMBS - 1; k++) begin
               h_ff[k] <= h_ff[k+1];
            end
            h_ff[NUM_LIMBS-1] <= HACC_W'(chain_sum[LIMB_W-1:0]);
            c_ff <= chain_sum[D_W:LIMB_W];
         end
         ST_FOLD: begin
            h_ff[0] <= HACC_W'(fold_sum[LIMB_W-1:0]);
            c_ff    <= C_W'(fold_sum[F_W-1:LIMB_W]);
         end
         ST_CARRY: begin
            h_ff[1] <= h_ff[1] + HACC_W'(c_ff);
         end
         ST_DONE: begin
            if (load_out) begin
               for (int k = 0; k < NUM_LIMBS; k++) begin
                  out_ff[k] <= h_ff[k];
               end
            end
         end
         default: ;
      endcase
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.acc_limb0 = out_ff[0][LIMB_W-1:0];
   assign rsp_bus.acc_limb1 = out_ff[1];
   assign rsp_bus.acc_limb2 = out_ff[2][LIMB_W-1:0];
   assign rsp_bus.acc_limb3 = out_ff[3][LIMB_W-1:0];
   assign rsp_bus.acc_limb4 = out_ff[4][LIMB_W-1:0];

   // ---------------- assertions ----------------
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("response beat raised outside completion");

   a_accept_starts_mul: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_MUL && cnt_ff == '0)
      else $error("accepted beat did not start the multiply");

   a_mul_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MUL |-> cnt_ff < CNT_W'(A_W))
      else $error("multiply beat count overran");

   a_acc_matches_out: assert property (@(posedge clock) disable iff (reset)
      load_out |=> acc_ff[1] == out_ff[1] && acc_ff[0] == out_ff[0])
      else $error("stored accumulator differs from delivered result");

endmodule

>>> sv/pba_mac_lane.sv
// Bit-serial multiply-accumulate lane producing one product column.
`timescale 1ns / 1ps

module pba_mac_lane (
   input  logic                                          clock,
   input  pba_pkg::lane_ctl_type                         ctl,
   input  logic [pba_pkg::NUM_LIMBS-1:0]                 a_bits,
   input  logic [pba_pkg::COEF_W-1:0]                    coef [pba_pkg::NUM_LIMBS],
   input  logic [pba_pkg::D_W-1:0]                       d_in,
   output logic [pba_pkg::D_W-1:0]                       d_out
);
   import pba_pkg::*;

   logic [LACC_W-1:0] acc_ff;
   logic [A_W-1:0]    low_ff;
   logic [LACC_W:0]   psum;
   logic [LACC_W:0]   total;

   // LSB first: one bit of each summed limb per cycle while ctl.step is set, low bits retire into low_ff
   always_comb begin
      psum = '0;
      for (int i = 0; i < NUM_LIMBS; i++) begin
         if (a_bits[i]) begin
            psum = psum + (LACC_W + 1)'(coef[i]);
         end
      end
      total = {1'b0, acc_ff} + psum;
   end

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         acc_ff <= '0;
      end else if (ctl.step) begin
         acc_ff <= total[LACC_W:1];
         low_ff <= {total[0], low_ff[A_W-1:1]};
      end else if (ctl.shift) begin
         {acc_ff, low_ff} <= d_in;
      end
   end

   assign d_out = {acc_ff, low_ff};

endmodule
